/* sv/fpms_pkg.sv */
// Shared types and constants for the fixed-partition multi-stack.
// Used by fpms_issue and fixed_partition_multi_stack; depends on nothing.
package fpms_pkg;

    localparam int SID_W = 3;
    localparam int VAL_W = 32;
    localparam int CNT_W = 8;
    // Widest region address: 7 * 255 + 255 fits in 11 bits.
    localparam int SUM_W = 11;
    localparam logic [CNT_W-1:0] CAP_RESET = 8'd128;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_TOP  = 2'd2,
        OP_SIZE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                     op;
        logic [SID_W-1:0]        stack_id;
        logic signed [VAL_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        element_count;
        t_status                 status;
    } t_rsp;

    // Decision made when a request is taken, carried while the memory read is in flight.
    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             use_mem;
    } t_iss;

endpackage

/* sv/fixed_partition_multi_stack.sv */
// Top level of the fixed-partition multi-stack.
// Depends on fpms_pkg, fpms_issue and fpms_ram.

// Several stacks share one word memory, each owning a region of stack_capacity words
// that starts at stack_id * stack_capacity. A request word pushes, pops, reads the top
// or reads the size of one stack and always yields exactly one response word carrying
// the word read, the stack's element count after the request and a status (ok, empty
// on pop or top, full on push). Flagged requests change nothing. The block takes one
// request word per cycle unless the output stalls; decode and memory access happen as
// the request is taken, into the stage register and the memory's registered read data,
// and the response moves to the output register once that is free. Per-stack counts
// live in flip-flops and are updated when the request is taken, so the next request
// already sees them; a push writes the memory before any following read of the
// same word, so no forwarding path is needed. The memory content is undefined after
// reset and needs no clearing pass; the counts and the capacity register (128) reset at
// once. Write stack_capacity only while no request is outstanding.
module fixed_partition_multi_stack #(
    parameter int MEM_WORDS  = 1024,
    parameter int NUM_STACKS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  fpms_pkg::t_req             i_req,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output fpms_pkg::t_rsp             o_rsp,
    input  logic                       i_cfg_we,
    input  logic [fpms_pkg::CNT_W-1:0] i_cfg_wdata
);

    localparam int RAM_AW = $clog2(MEM_WORDS);

    logic [fpms_pkg::CNT_W-1:0] r_cap;
    logic                       r_s1_vld;
    fpms_pkg::t_iss             r_s1;
    logic                       r_rsp_vld;
    fpms_pkg::t_rsp             r_rsp;
    fpms_pkg::t_rsp             n_rsp;
    fpms_pkg::t_iss             iss;
    logic                       fire;
    logic                       s1_adv;
    logic                       mem_en;
    logic                       mem_we;
    logic [RAM_AW-1:0]          mem_addr;
    logic [fpms_pkg::VAL_W-1:0] mem_wdata;
    logic [fpms_pkg::VAL_W-1:0] mem_rdata;

    // The stage holding a response in flight moves on when the output register is free.
    assign s1_adv      = !r_rsp_vld || i_rsp_ready;
    assign o_req_ready = !r_s1_vld || s1_adv;
    assign fire        = i_req_valid && o_req_ready;

    fpms_issue #(
        .MEM_WORDS (MEM_WORDS),
        .NUM_STACKS(NUM_STACKS)
    ) u_issue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_req      (i_req),
        .i_cap      (r_cap),
        .o_iss      (iss),
        .o_mem_en   (mem_en),
        .o_mem_we   (mem_we),
        .o_mem_addr (mem_addr),
        .o_mem_wdata(mem_wdata)
    );

    // The read register only changes on a new read, which needs a taken request, so the
    // data stays put while the stage waits on the output side.
    fpms_ram #(
        .WIDTH(fpms_pkg::VAL_W),
        .DEPTH(MEM_WORDS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_en   (mem_en),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    always_comb begin
        n_rsp.read_value    = r_s1.use_mem ? $signed(mem_rdata) : '0;
        n_rsp.element_count = r_s1.count;
        n_rsp.status        = r_s1.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= fpms_pkg::CAP_RESET;
            r_s1_vld  <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (o_req_ready) begin
                r_s1_vld <= fire;
            end
            if (s1_adv) begin
                r_rsp_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1 <= iss;
        end
        if (r_s1_vld && s1_adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

`ifndef SYNTH
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |=> r_s1_vld && $stable(r_s1))
        else $error("in-flight request changed while the output was blocked");

    a_taken_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_s1_vld)
        else $error("taken request did not reach the memory stage");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != fpms_pkg::ST_OK |-> o_rsp.read_value == '0)
        else $error("flagged response carries a nonzero word");
`endif

endmodule

/* sv/fpms_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module fpms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fpms_issue.sv */
// Request decode for the multi-stack: per-stack counts, region address and limit checks.
// Depends on fpms_pkg; drives the memory port of fpms_ram.
module fpms_issue #(
    parameter int MEM_WORDS  = 1024,
    parameter int NUM_STACKS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  fpms_pkg::t_req               i_req,
    input  logic [fpms_pkg::CNT_W-1:0]   i_cap,
    output fpms_pkg::t_iss               o_iss,
    output logic                         o_mem_en,
    output logic                         o_mem_we,
    output logic [$clog2(MEM_WORDS)-1:0] o_mem_addr,
    output logic [fpms_pkg::VAL_W-1:0]   o_mem_wdata
);

    localparam int IDX_W = $clog2(NUM_STACKS);
    localparam int RAM_AW = $clog2(MEM_WORDS);

    logic [fpms_pkg::CNT_W-1:0] r_counts [NUM_STACKS];
    logic [fpms_pkg::CNT_W-1:0] n_cnt;
    logic [fpms_pkg::CNT_W-1:0] cnt;
    logic [IDX_W-1:0]           idx;
    logic                       sid_ok;
    logic [fpms_pkg::SUM_W-1:0] base;
    logic [fpms_pkg::SUM_W-1:0] a_push;
    logic [fpms_pkg::SUM_W-1:0] a_top;
    logic [fpms_pkg::SUM_W-1:0] addr;
    logic                       push_fit;
    logic                       top_fit;
    logic                       upd;
    logic                       we;
    logic                       re;
    logic                       use_mem;
    fpms_pkg::t_status          status;

    assign idx    = IDX_W'(i_req.stack_id);
    assign sid_ok = 32'(i_req.stack_id) < 32'(NUM_STACKS);
    assign cnt    = sid_ok ? r_counts[idx] : '0;

    assign base     = fpms_pkg::SUM_W'(i_req.stack_id) * fpms_pkg::SUM_W'(i_cap);
    assign a_push   = base + fpms_pkg::SUM_W'(cnt);
    assign a_top    = a_push - fpms_pkg::SUM_W'(1);
    assign push_fit = 32'(a_push) < 32'(MEM_WORDS);
    assign top_fit  = 32'(a_top) < 32'(MEM_WORDS);

    always_comb begin
        n_cnt   = cnt;
        status  = fpms_pkg::ST_OK;
        upd     = 1'b0;
        we      = 1'b0;
        re      = 1'b0;
        use_mem = 1'b0;
        addr    = a_push;
        case (i_req.op)
            fpms_pkg::OP_PUSH: begin
                if (!sid_ok || cnt >= i_cap || !push_fit) begin
                    status = fpms_pkg::ST_FULL;
                end else begin
                    n_cnt = cnt + 1'b1;
                    upd   = 1'b1;
                    we    = 1'b1;
                end
            end
            fpms_pkg::OP_POP, fpms_pkg::OP_TOP: begin
                if (!sid_ok || cnt == '0) begin
                    status = fpms_pkg::ST_EMPTY;
                end else begin
                    // A word outside the memory reads as zero.
                    addr    = a_top;
                    re      = top_fit;
                    use_mem = top_fit;
                    if (i_req.op == fpms_pkg::OP_POP) begin
                        n_cnt = cnt - 1'b1;
                        upd   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_counts[k] <= '0;
            end
        end else if (i_fire && upd) begin
            r_counts[idx] <= n_cnt;
        end
    end

    assign o_iss.status  = status;
    assign o_iss.count   = n_cnt;
    assign o_iss.use_mem = use_mem;
    assign o_mem_en      = i_fire && (we || re);
    assign o_mem_we      = we;
    assign o_mem_addr    = RAM_AW'(addr);
    assign o_mem_wdata   = i_req.push_value;

endmodule
